### rtl/rpa_pkg.sv
// shared constants and helpers for the point rotation pipeline
package rpa_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int DIR_WIDTH    = 16;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 22;
	localparam int CORDIC_W     = 34;
	localparam int ZW           = 26;
	localparam int TRIG_W       = 16;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032875;
	localparam logic signed [15:0] TRIG_ONE = 16'sd16384;

	// arctangent of 2^-i in units of 2^24 per turn
	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0: r = 26'sd2097152;
			1: r = 26'sd1238021;
			2: r = 26'sd654136;
			3: r = 26'sd332050;
			4: r = 26'sd166669;
			5: r = 26'sd83416;
			6: r = 26'sd41718;
			7: r = 26'sd20860;
			8: r = 26'sd10430;
			9: r = 26'sd5215;
			10: r = 26'sd2608;
			11: r = 26'sd1304;
			12: r = 26'sd652;
			13: r = 26'sd326;
			14: r = 26'sd163;
			15: r = 26'sd81;
			16: r = 26'sd41;
			17: r = 26'sd20;
			18: r = 26'sd10;
			19: r = 26'sd5;
			20: r = 26'sd3;
			21: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/rotate_point_about_axis.sv
// point rotation about an arbitrary 3d axis, fully pipelined
//
// Input channel: point, pivot, axis direction (Q1.14) and angle
// (65536 units per turn), qualified by in_valid / in_stall. Output channel:
// rotated point (Q16.16, saturated), qualified by out_valid / out_stall.
// A transaction is taken when valid is high and stall is low.
//
// Throughput: one transaction per cycle while the receiver does not stall.
// The 22 CORDIC iterations for sine and cosine run one per stage, in
// parallel with the difference and delay stages. Of the other stages,
// the first folds the angle, four hold one multiplier level each (the
// first beside the sine and cosine rounding) and the last adds and
// saturates.
//
// Reset clears every stage valid bit; no output appears until new input.
// When the receiver stalls, the whole pipeline holds (in_stall follows
// out_stall whenever the final stage holds a result), so nothing is lost
// or repeated.
module rotate_point_about_axis #(
	parameter int COORD_WIDTH = rpa_pkg::COORD_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [COORD_WIDTH-1:0] pivot_x,
	input  logic signed [COORD_WIDTH-1:0] pivot_y,
	input  logic signed [COORD_WIDTH-1:0] pivot_z,
	input  logic signed [rpa_pkg::DIR_WIDTH-1:0] dir_x,
	input  logic signed [rpa_pkg::DIR_WIDTH-1:0] dir_y,
	input  logic signed [rpa_pkg::DIR_WIDTH-1:0] dir_z,
	input  logic signed [rpa_pkg::ANGLE_WIDTH-1:0] angle,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [COORD_WIDTH-1:0] rotated_x,
	output logic signed [COORD_WIDTH-1:0] rotated_y,
	output logic signed [COORD_WIDTH-1:0] rotated_z
);
	localparam int N  = rpa_pkg::CORDIC_STEPS;
	localparam int CW = rpa_pkg::CORDIC_W;
	localparam int ZW = rpa_pkg::ZW;
	localparam int DW = COORD_WIDTH + 1;     // difference
	localparam int PW = DW + 2;              // d*k rounded product
	localparam int TW = PW + 3;              // dot / cross sums
	localparam int UW = TW + 2;              // t*k
	localparam int VW = UW + 2;              // (t*k)*omc
	localparam int RW = VW + 3;              // final sum
	localparam int LAT = N + 6;              // stages of valid bits
	localparam int DS = rpa_pkg::DIR_WIDTH;

	typedef logic signed [CW-1:0] cv_t;
	typedef logic signed [ZW-1:0] zv_t;

	// round half up of a*b / 2^14
	function automatic logic signed [RW-1:0] mulq(input logic signed [RW-1:0] a,
		input logic signed [17:0] b);
		logic signed [RW+17:0] p;
		p = a * b + (RW+18)'(8192);
		return RW'(p >>> 14);
	endfunction

	logic advance;
	logic [LAT-1:0] vld_q;

	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;
	assign out_valid = vld_q[LAT-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// ---------------- trig path: fold and cordic ----------------
	cv_t cx_q [N+1];
	cv_t cy_q [N+1];
	zv_t cz_q [N+1];
	logic flip_q [N+1];

	// stage 1: fold the angle
	always_ff @(posedge clk) begin
		if (advance) begin
			logic signed [16:0] a;
			logic f;
			a = 17'(angle);
			f = 1'b0;
			if (a > 17'sd16384) begin
				a = a - 17'sd32768;
				f = 1'b1;
			end else if (a < -17'sd16384) begin
				a = a + 17'sd32768;
				f = 1'b1;
			end
			flip_q[0] <= f;
			cz_q[0] <= ZW'(a) <<< 8;
			cx_q[0] <= rpa_pkg::CORDIC_GAIN;
			cy_q[0] <= '0;
		end
	end

	// one cordic iteration per stage
	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (advance) begin
				flip_q[i+1] <= flip_q[i];
				if (cz_q[i] >= 0) begin
					cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
					cz_q[i+1] <= cz_q[i] - rpa_pkg::atan_step(i);
				end else begin
					cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
					cz_q[i+1] <= cz_q[i] + rpa_pkg::atan_step(i);
				end
			end
		end
	end

	// round to Q1.14, clamp, unfold
	function automatic logic signed [17:0] trig_round(input cv_t v, input logic f);
		logic signed [CW:0] r;
		logic signed [17:0] t;
		r = ((CW+1)'(v) + (CW+1)'(32768)) >>> 16;
		if (r > (CW+1)'(16384))       t = 18'sd16384;
		else if (r < -(CW+1)'(16384)) t = -18'sd16384;
		else                          t = 18'(r);
		return f ? -t : t;
	endfunction

	logic signed [17:0] cos_s, sin_s, omc_s;
	always_ff @(posedge clk) begin
		if (advance) begin
			cos_s <= trig_round(cx_q[N], flip_q[N]);
			sin_s <= trig_round(cy_q[N], flip_q[N]);
			omc_s <= 18'sd16384 - trig_round(cx_q[N], flip_q[N]);
		end
	end

	// ---------------- coordinate path ----------------
	// delay line of the inputs to line up with the cordic
	localparam int DL = N + 1;
	logic signed [COORD_WIDTH-1:0] pv_dl [DL][3];
	logic signed [DW-1:0] d_dl [DL][3];
	logic signed [DS-1:0] k_dl [DL][3];

	always_ff @(posedge clk) begin
		if (advance) begin
			pv_dl[0][0] <= pivot_x; pv_dl[0][1] <= pivot_y; pv_dl[0][2] <= pivot_z;
			d_dl[0][0] <= DW'(point_x) - DW'(pivot_x);
			d_dl[0][1] <= DW'(point_y) - DW'(pivot_y);
			d_dl[0][2] <= DW'(point_z) - DW'(pivot_z);
			k_dl[0][0] <= dir_x; k_dl[0][1] <= dir_y; k_dl[0][2] <= dir_z;
			for (int i = 1; i < DL; i++) begin
				pv_dl[i] <= pv_dl[i-1];
				d_dl[i]  <= d_dl[i-1];
				k_dl[i]  <= k_dl[i-1];
			end
		end
	end

	// stage a: the nine d*k products
	logic signed [PW-1:0] dk_s [3][3];
	logic signed [DW-1:0] d_a [3];
	logic signed [COORD_WIDTH-1:0] pv_a [3];
	logic signed [DS-1:0] k_a [3];
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					dk_s[i][j] <= PW'(mulq(RW'(d_dl[DL-1][i]), 18'(k_dl[DL-1][j])));
				end
			end
			d_a  <= d_dl[DL-1];
			pv_a <= pv_dl[DL-1];
			k_a  <= k_dl[DL-1];
		end
	end

	// stage b: dot and cross sums, d*cos
	logic signed [TW-1:0] t_s;
	logic signed [TW-1:0] cr_s [3];
	logic signed [PW-1:0] dc_s [3];
	logic signed [COORD_WIDTH-1:0] pv_b [3];
	logic signed [DS-1:0] k_b [3];
	always_ff @(posedge clk) begin
		if (advance) begin
			t_s <= TW'(dk_s[0][0]) + TW'(dk_s[1][1]) + TW'(dk_s[2][2]);
			cr_s[0] <= TW'(dk_s[2][1]) - TW'(dk_s[1][2]);
			cr_s[1] <= TW'(dk_s[0][2]) - TW'(dk_s[2][0]);
			cr_s[2] <= TW'(dk_s[1][0]) - TW'(dk_s[0][1]);
			for (int i = 0; i < 3; i++) begin
				dc_s[i] <= PW'(mulq(RW'(d_a[i]), cos_s));
			end
			pv_b <= pv_a;
			k_b  <= k_a;
		end
	end

	// trig values aligned to later stages
	logic signed [17:0] sin_b, omc_b, omc_c;
	always_ff @(posedge clk) begin
		if (advance) begin
			sin_b <= sin_s;
			omc_b <= omc_s;
			omc_c <= omc_b;
		end
	end

	// stage c: t*k and cross*sin
	logic signed [UW-1:0] tk_s [3];
	logic signed [TW-1:0] cs_s [3];
	logic signed [PW-1:0] dc_c [3];
	logic signed [COORD_WIDTH-1:0] pv_c [3];
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				tk_s[i] <= UW'(mulq(RW'(t_s), 18'(k_b[i])));
				cs_s[i] <= TW'(mulq(RW'(cr_s[i]), sin_b));
			end
			dc_c <= dc_s;
			pv_c <= pv_b;
		end
	end

	// stage d: (t*k)*(1-cos) and partial sum
	logic signed [VW-1:0] tko_s [3];
	logic signed [RW-1:0] ps_s [3];
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				tko_s[i] <= VW'(mulq(RW'(tk_s[i]), omc_c));
				ps_s[i]  <= RW'(pv_c[i]) + RW'(dc_c[i]) + RW'(cs_s[i]);
			end
		end
	end

	// stage e: final sum and saturation
	localparam logic signed [RW-1:0] LIM_HI = RW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam logic signed [RW-1:0] LIM_LO = -LIM_HI - RW'(1);
	logic signed [COORD_WIDTH-1:0] res_s [3];
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [RW-1:0] s;
				s = ps_s[i] + RW'(tko_s[i]);
				if (s > LIM_HI)      res_s[i] <= LIM_HI[COORD_WIDTH-1:0];
				else if (s < LIM_LO) res_s[i] <= LIM_LO[COORD_WIDTH-1:0];
				else                 res_s[i] <= s[COORD_WIDTH-1:0];
			end
		end
	end

	assign rotated_x = res_s[0];
	assign rotated_y = res_s[1];
	assign rotated_z = res_s[2];

endmodule

### tb/rotate_point_about_axis_checker.sv
// transaction checker for the point rotation block: predicts and compares results
`timescale 1ns / 100ps

module rotate_point_about_axis_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] pivot_x,
	input  logic signed [31:0] pivot_y,
	input  logic signed [31:0] pivot_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic signed [15:0] angle,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [31:0] rotated_x,
	input  logic signed [31:0] rotated_y,
	input  logic signed [31:0] rotated_z,
	output int   mismatches,
	output int   pending
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} coord_t;

	coord_t rotated_q[$];

	// floor division by 2^n
	function automatic longint floor_div(longint v, int n);
		return v >>> n;
	endfunction

	// round half up of a*b / 2^14, wide enough for any operand here
	function automatic longint scale_q14(longint a, longint b);
		logic signed [95:0] p;
		p = 96'(signed'(a)) * 96'(signed'(b)) + 96'sd8192;
		return longint'(p >>> 14);
	endfunction

	// cordic sine and cosine in q1.14
	task automatic trig_of(input logic signed [15:0] ang_in, output longint c, output longint s);
		longint ang, x, y, z, xs, ys;
		bit flip;
		ang = ang_in;
		flip = 0;
		if (ang > 16384) begin
			ang -= 32768;
			flip = 1;
		end else if (ang < -16384) begin
			ang += 32768;
			flip = 1;
		end
		x = rpa_pkg::CORDIC_GAIN;
		y = 0;
		z = ang * 256;
		for (int i = 0; i < rpa_pkg::CORDIC_STEPS; i++) begin
			xs = floor_div(x, i);
			ys = floor_div(y, i);
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= rpa_pkg::atan_step(i);
			end else begin
				x += ys;
				y -= xs;
				z += rpa_pkg::atan_step(i);
			end
		end
		x = floor_div(x + 32768, 16);
		y = floor_div(y + 32768, 16);
		x = x > 16384 ? 16384 : (x < -16384 ? -16384 : x);
		y = y > 16384 ? 16384 : (y < -16384 ? -16384 : y);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// rotated point from one input transaction
	task automatic predict_rotation(output coord_t r);
		longint a[3], k[3], d[3], cr[3], res[3];
		longint c, s, t, omc;
		a[0] = pivot_x; a[1] = pivot_y; a[2] = pivot_z;
		k[0] = dir_x; k[1] = dir_y; k[2] = dir_z;
		d[0] = longint'(point_x) - a[0];
		d[1] = longint'(point_y) - a[1];
		d[2] = longint'(point_z) - a[2];
		trig_of(angle, c, s);
		omc = 16384 - c;
		t = scale_q14(d[0], k[0]) + scale_q14(d[1], k[1]) + scale_q14(d[2], k[2]);
		cr[0] = scale_q14(d[2], k[1]) - scale_q14(d[1], k[2]);
		cr[1] = scale_q14(d[0], k[2]) - scale_q14(d[2], k[0]);
		cr[2] = scale_q14(d[1], k[0]) - scale_q14(d[0], k[1]);
		for (int j = 0; j < 3; j++)
			res[j] = a[j] + scale_q14(d[j], c) + scale_q14(cr[j], s)
				+ scale_q14(scale_q14(t, k[j]), omc);
		r.x = sat32(res[0]);
		r.y = sat32(res[1]);
		r.z = sat32(res[2]);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// watch both channels
	always @(posedge clk) begin
		coord_t r, e;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_rotation(r);
				rotated_q.push_back(r);
			end
			if (out_valid && !out_stall) begin
				if (rotated_q.size() == 0) begin
					report_mismatch("unexpected transaction", rotated_x, 0);
				end else begin
					e = rotated_q.pop_front();
					if (rotated_x !== e.x) report_mismatch("rotated_x", rotated_x, e.x);
					if (rotated_y !== e.y) report_mismatch("rotated_y", rotated_y, e.y);
					if (rotated_z !== e.z) report_mismatch("rotated_z", rotated_z, e.z);
				end
			end
			pending = rotated_q.size();
		end
	end

endmodule

### tb/rotate_point_about_axis_test.sv
// testbench top for the point rotation block: stimulus and verdict
`timescale 1ns / 100ps

module rotate_point_about_axis_test;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 1;
	logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
	logic signed [31:0] pivot_x = 0, pivot_y = 0, pivot_z = 0;
	logic signed [15:0] dir_x = 0, dir_y = 0, dir_z = 0, angle = 0;
	logic signed [31:0] rotated_x, rotated_y, rotated_z;
	int mismatches, pending;
	int cycles = 0;
	bit calm = 0;

	localparam int CYCLE_LIMIT = 200000;

	always #5 clk = ~clk;

	rotate_point_about_axis u_dut (.*);
	rotate_point_about_axis_checker u_chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver stalls at random except in the calm stretch
	always @(negedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
		endcase
	endfunction

	function automatic logic [15:0] rand_dir();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// present one transaction and hold it until taken
	task automatic send_item(input logic [31:0] px, py, pz, ax, ay, az,
		input logic [15:0] kx, ky, kz, an);
		while (!calm && $urandom_range(99) < 38) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		point_x <= px; point_y <= py; point_z <= pz;
		pivot_x <= ax; pivot_y <= ay; pivot_z <= az;
		dir_x <= kx; dir_y <= ky; dir_z <= kz; angle <= an;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] dirs [3];
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: axes, extreme angles, extreme coordinates, odd directions
		send_item(65536, 0, 0, 0, 0, 0, 0, 0, 16384, 16384);
		send_item(65536, 131072, 0, 0, 0, 0, 16384, 0, 0, 16'h8000);
		send_item(65536, 0, 0, 0, 0, 0, 0, 16384, 0, 16'h7fff);
		send_item(0, 65536, 0, 0, 0, 0, 0, 0, -16384, -16384);
		send_item(0, 65536, 0, 0, 0, 0, 0, 0, 16384, 16385);
		send_item(0, 65536, 0, 0, 0, 0, 0, 0, 16384, -16385);
		send_item(0, 65536, 0, 0, 0, 0, 0, 0, 16384, 0);
		send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 9459, 9459, 9459, 12000);
		send_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
		send_item(32'h12345678, 32'hfedcba98, 32'h0, 32'h1000, 32'h2000, 32'h3000,
			16'hffff, 16'h7fff, 16'h5555, 16'haaaa);
		send_item(100, 200, 300, 100, 200, 300, 9459, 9459, 9459, 5000);
		send_item(32'h40000000, 0, 0, 0, 0, 0, 0, 16384, 0, 16384);
		send_item(65536, 65536, 65536, 0, 0, 0, 0, 0, 0, 8192);
		// random part, calm stretch in the middle
		for (int n = 0; n < 1750; n++) begin
			calm = (n >= 700 && n < 900);
			for (int j = 0; j < 3; j++) dirs[j] = rand_dir();
			send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), dirs[0], dirs[1], dirs[2], $urandom);
		end
		calm = 0;
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
